@@ design/sap_pkg.sv @@
// Shared widths and constants for the shelf atlas packer.
package sap_pkg;

  localparam int DIM_W       = 13;  // rectangle and atlas dimension fields
  localparam int POS_W       = 12;  // placement coordinate fields
  localparam int IDX_W       = 16;  // atlas index field
  localparam int SHIFT_W     = $clog2(DIM_W + 1);
  localparam int IN_FIELDS_W = 2 * DIM_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = 2 * POS_W + IDX_W + 2 * DIM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [DIM_W-1:0] RESET_MIN_SIZE = DIM_W'(256);
  localparam logic [IDX_W-1:0] ATLAS_IDX_INIT = '1;

endpackage

@@ design/sap_grow.sv @@
// Atlas dimension growth: double until the rectangle is covered, saturate at the maximum.
module sap_grow
  import sap_pkg::*;
#(
  parameter int MAX_ATLAS_SIZE = 4096
) (
  input  logic [((($clog2(MAX_ATLAS_SIZE + 1)) > DIM_W) ?
                 $clog2(MAX_ATLAS_SIZE + 1) : DIM_W)-1:0] size_i,
  input  logic [DIM_W-1:0]                              need_i,
  output logic [((($clog2(MAX_ATLAS_SIZE + 1)) > DIM_W) ?
                 $clog2(MAX_ATLAS_SIZE + 1) : DIM_W)-1:0] size_o
);

  localparam int SW = ($clog2(MAX_ATLAS_SIZE + 1) > DIM_W) ?
                      $clog2(MAX_ATLAS_SIZE + 1) : DIM_W;
  localparam int PW = SW + DIM_W;
  localparam logic [SW-1:0] MAX_S = SW'(MAX_ATLAS_SIZE);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_ATLAS_SIZE);

  logic [DIM_W:0]   hit;
  logic [SHIFT_W-1:0] sel;
  logic [PW-1:0]    shifted;

  // Every doubling count is tested at once; the smallest that covers wins.
  always_comb begin
    for (int k = 0; k <= DIM_W; k++) begin
      hit[k] = ((PW'(size_i) << k) >= PW'(need_i));
    end
    sel = SHIFT_W'(DIM_W);
    for (int k = DIM_W; k >= 0; k--) begin
      if (hit[k]) sel = SHIFT_W'(k);
    end
    shifted = PW'(size_i) << sel;
    if ((size_i >= SW'(need_i)) || (size_i >= MAX_S)) begin
      size_o = size_i;
    end else if (shifted > MAX_P) begin
      size_o = MAX_S;
    end else begin
      size_o = shifted[SW-1:0];
    end
  end

endmodule

@@ design/shelf_atlas_packer.sv @@
// Shelf atlas packer top level: placement logic between an input and a result register.
//
// Places one rectangle per clock unless a stall on out_ holds it: an item
// accepted on in_ is held in the input register while the placement, shelf
// update and atlas growth are worked out against the packer state, and its
// result goes to the result register and leaves on out_. The rate is set by the
// single state update per item (cursor, shelf and atlas size are read and
// rewritten in the same cycle). The result register and the input register let
// a new transfer be taken while a result is still waiting on out_. A zero width
// or height is placed as one pixel. The minimum atlas size is written through
// cfg_ into the current size registers, only while no atlas has been started;
// the user is to write it while the block is idle, which is not enforced.
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int MAX_ATLAS_SIZE = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // rect_width [12:0], rect_height [25:13], zero padding above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // place_x [11:0], place_y [23:12], atlas_index [39:24],
  // atlas_width [52:40], atlas_height [65:53], zero padding above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // new_atlas [0]
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [DIM_W-1:0]       cfg_wr_data
);

  localparam int SW = ($clog2(MAX_ATLAS_SIZE + 1) > DIM_W) ?
                      $clog2(MAX_ATLAS_SIZE + 1) : DIM_W;
  localparam logic [SW-1:0] MAX_S = SW'(MAX_ATLAS_SIZE);

  logic             in_vld_r;
  logic [DIM_W-1:0] in_w_r, in_h_r;
  logic             out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic             out_user_r;

  logic [SW-1:0]    cur_w_r, cur_h_r;
  logic [SW-1:0]    cursor_x_r, shelf_top_r, shelf_bot_r;
  logic             atlas_open_r;
  logic [IDX_W-1:0] atlas_cnt_r;

  logic             advance, step;
  logic [DIM_W-1:0] in_w_fix, in_h_fix;
  logic [SW-1:0]    rw, rh, room, u0, v0, u, v;
  logic             wrap, fit_pre, placed;
  logic [SW-1:0]    grow_w, grow_h;
  logic [SW-1:0]    cur_w_nxt, cur_h_nxt, cursor_x_nxt, shelf_bot_nxt, sb_base, bot;
  logic [SW:0]      sum_x, sum_y;
  logic [IDX_W-1:0] atlas_cnt_nxt;
  logic [SW-1:0]    cfg_size;

  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  assign in_w_fix = (in_tdata[DIM_W-1:0] == '0) ? DIM_W'(1) : in_tdata[DIM_W-1:0];
  assign in_h_fix = (in_tdata[2*DIM_W-1:DIM_W] == '0) ? DIM_W'(1)
                                                      : in_tdata[2*DIM_W-1:DIM_W];

  sap_grow #(.MAX_ATLAS_SIZE(MAX_ATLAS_SIZE)) u_grow_w (
    .size_i (cur_w_r),
    .need_i (in_w_r),
    .size_o (grow_w)
  );

  sap_grow #(.MAX_ATLAS_SIZE(MAX_ATLAS_SIZE)) u_grow_h (
    .size_i (cur_h_r),
    .need_i (in_h_r),
    .size_o (grow_h)
  );

  always_comb begin
    rw      = SW'(in_w_r);
    rh      = SW'(in_h_r);
    room    = cur_w_r - cursor_x_r;
    wrap    = rw > room;
    // open a new shelf at the shelf bottom when the current one has too little width left
    u0      = wrap ? '0 : cursor_x_r;
    v0      = wrap ? shelf_bot_r : shelf_top_r;
    fit_pre = atlas_open_r && (rw <= cur_w_r) && (rh <= cur_h_r)
              && (cursor_x_r <= cur_w_r) && (shelf_bot_r <= cur_h_r);
    placed  = fit_pre && (v0 <= cur_h_r) && (rh <= (cur_h_r - v0));

    cur_w_nxt     = placed ? cur_w_r : grow_w;
    cur_h_nxt     = placed ? cur_h_r : grow_h;
    u             = placed ? u0 : '0;
    v             = placed ? v0 : '0;
    sb_base       = placed ? shelf_bot_r : '0;
    atlas_cnt_nxt = placed ? atlas_cnt_r : IDX_W'(atlas_cnt_r + 1'b1);

    // clamp cursor and bottom at the atlas edges
    sum_x        = {1'b0, u} + {1'b0, rw};
    sum_y        = {1'b0, v} + {1'b0, rh};
    cursor_x_nxt = (sum_x > {1'b0, cur_w_nxt}) ? cur_w_nxt : sum_x[SW-1:0];
    bot          = (sum_y > {1'b0, cur_h_nxt}) ? cur_h_nxt : sum_y[SW-1:0];
    shelf_bot_nxt = (bot > sb_base) ? bot : sb_base;

    if (cfg_wr_data == '0) begin
      cfg_size = SW'(1);
    end else if (SW'(cfg_wr_data) > MAX_S) begin
      cfg_size = MAX_S;
    end else begin
      cfg_size = SW'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      cur_w_r      <= SW'(RESET_MIN_SIZE);
      cur_h_r      <= SW'(RESET_MIN_SIZE);
      cursor_x_r   <= '0;
      shelf_top_r  <= '0;
      shelf_bot_r  <= '0;
      atlas_open_r <= 1'b0;
      atlas_cnt_r  <= ATLAS_IDX_INIT;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (step) begin
        cur_w_r      <= cur_w_nxt;
        cur_h_r      <= cur_h_nxt;
        cursor_x_r   <= cursor_x_nxt;
        shelf_top_r  <= v;
        shelf_bot_r  <= shelf_bot_nxt;
        atlas_open_r <= 1'b1;
        atlas_cnt_r  <= atlas_cnt_nxt;
      end
      // the size only matters while no atlas has been started
      if (cfg_wr_en) begin
        if (!atlas_open_r) begin
          cur_w_r <= cfg_size;
          cur_h_r <= cfg_size;
        end
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_w_r <= in_w_fix;
      in_h_r <= in_h_fix;
    end
    if (step) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, cur_h_nxt[DIM_W-1:0], cur_w_nxt[DIM_W-1:0],
                     atlas_cnt_nxt, v[POS_W-1:0], u[POS_W-1:0]};
      out_user_r <= !placed;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_vld_r;

`ifndef SYNTH
  // a fresh atlas always places at the origin
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[2*POS_W-1:0] == '0))
    else $error("fresh atlas placement not at origin");

  // the atlas index moves up by one whenever a new atlas starts
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && !placed) |=> (atlas_cnt_r == IDX_W'($past(atlas_cnt_r) + 1'b1)))
    else $error("atlas index did not advance on new atlas");

  assert property (@(posedge clk) disable iff (!rst_n)
    step |=> atlas_open_r)
    else $error("atlas not open after placement");

  // cursor and shelf bottom never leave the atlas
  assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_x_r <= cur_w_r) && (shelf_bot_r <= cur_h_r))
    else $error("shelf state outside atlas");
`endif

endmodule
